// ===== hw/rtl/sha256_hash_core_top_assert.svh =====
// Assertion macros for the SHA-256 core.
`ifndef SHA256_HASH_CORE_TOP_ASSERT_SVH
`define SHA256_HASH_CORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SHA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SHA_ASSERT(label, clk, rst, prop)
`define SHA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/sha_pkg.sv =====
// Package: SHA-256 constants, round functions and sequencer states.
package sha_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic start;
  } rnd_ctl_t;

  function automatic logic [31:0] iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 32'h6a09e667;
      3'd1: iv = 32'hbb67ae85;
      3'd2: iv = 32'h3c6ef372;
      3'd3: iv = 32'ha54ff53a;
      3'd4: iv = 32'h510e527f;
      3'd5: iv = 32'h9b05688c;
      3'd6: iv = 32'h1f83d9ab;
      default: iv = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] rc(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    rc = k[t];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int s);
    ror = (x >> s) | (x << (32 - s));
  endfunction
endpackage

// ===== hw/rtl/sha_round.sv =====
// Round unit: one SHA-256 round per cycle with rolling 16-word schedule.
module sha_round import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rnd_ctl_t    ctl_in,
  input  logic [31:0] hash_in [8],
  input  logic [31:0] blk_in [16],
  output logic [31:0] work_out [8],
  output logic        done
);
  `include "sha256_hash_core_top_assert.svh"

  logic [31:0] w [16];
  logic [31:0] r [8];
  logic [5:0]  t;
  logic        busy;
  logic [31:0] wn, s0, s1, t1, t2;

  // Window is a shift line: w[0] is always the word of this round.
  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + rc(t) + w[0];
    t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      t <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        t <= '0;
      end else if (busy) begin
        t <= t + 6'd1;
        if (t == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      w <= blk_in;
      r <= hash_in;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4]; r[4] <= r[3] + t1;
      r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0]; r[0] <= t1 + t2;
    end
  end

  assign work_out = r;

  `SHA_ASSERT(a_no_restart, clk, rst, busy |-> !ctl_in.start)
  `SHA_ASSERT(a_done_end, clk, rst, done |-> $past(t) == 6'd63)
  `SHA_ASSERT(a_done_idle, clk, rst, done |-> !busy)
endmodule

// ===== hw/rtl/sha256_hash_core_top.sv =====
// Top level: byte packer, padding sequencer and digest output of the SHA-256 core.
// Takes one message byte per cycle while in ST_IDLE and drops ready while a block is
// padded or compresses and while the digest goes out. A full block is compressed in
// steps: start the round unit, run its 64 rounds, see it finish and fold the result into
// the hash. A closing beat adds a padding step (ST_PAD) before each block, one block or
// two when fewer than nine bytes are free after the message, then eight digest beats at
// the receiver's pace. A single round unit serves every block.
module sha256_hash_core_top import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  `include "sha256_hash_core_top_assert.svh"

  state_t state, state_next;
  logic [31:0] hash [8];
  logic [31:0] blk [16];
  logic [31:0] work [8];
  logic [60:0] count;
  logic        fin;     // closing in progress
  logic        lenblk;  // current compression is the final length block
  logic [2:0]  oidx;
  rnd_ctl_t    ctl;
  logic        rdone;
  logic        acc;
  logic [5:0]  pos;

  assign acc = in_valid && in_ready;
  assign pos = count[5:0];

  sha_round u_round (
    .clk(clk), .rst(rst), .ctl_in(ctl), .hash_in(hash), .blk_in(blk),
    .work_out(work), .done(rdone)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) begin
        if (byte_present && pos == 6'd63) state_next = ST_START;
        else if (last) state_next = ST_PAD;
      end
      ST_START: state_next = ST_ROUND;
      ST_ROUND: if (rdone) state_next = ST_ADD;
      ST_ADD: begin
        if (lenblk) state_next = ST_OUT;
        else if (fin) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD: state_next = ST_START;
      ST_OUT: if (out_ready && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    // start in the state after the block buffer is written
    ctl.start = (state == ST_START);
  end

  assign digest_word = hash[oidx];
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      fin <= 1'b0;
      lenblk <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= iv(3'(i));
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (acc) begin
          if (byte_present) count <= count + 61'd1;
          fin <= last;
          lenblk <= 1'b0;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + work[i];
        end
        ST_PAD: lenblk <= padded || (pos < 6'd56);
        ST_OUT: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            for (int i = 0; i < 8; i++) hash[i] <= iv(3'(i));
            count <= '0;
            fin <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Block buffer: pack bytes, then build the padding in ST_PAD.
  logic [3:0] wi;
  logic [4:0] sh;
  assign wi = pos[5:2];
  assign sh = {~pos[1:0], 3'b000};
  logic padded;  // 0x80 already placed in an earlier overflow block
  always_ff @(posedge clk) begin
    if (rst) padded <= 1'b0;
    else if (state == ST_IDLE) padded <= 1'b0;
    else if (state == ST_PAD && fin && !lenblk) padded <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && byte_present) begin
      if (pos[1:0] == 2'd0) blk[wi] <= {24'd0, data_byte} << sh;
      else blk[wi] <= blk[wi] | ({24'd0, data_byte} << sh);
    end else if (state == ST_PAD) begin
      if (!padded) begin
        // place 0x80, clear the rest and add the length if it fits
        if (pos[1:0] == 2'd0) blk[wi] <= {24'd0, PAD_BYTE} << sh;
        else blk[wi] <= blk[wi] | ({24'd0, PAD_BYTE} << sh);
        for (int i = 0; i < 16; i++) if (4'(i) > wi) blk[i] <= '0;
        if (pos < 6'd56) begin
          blk[14] <= {count[60:29]};
          blk[15] <= {count[28:0], 3'b000};
        end
      end else begin
        for (int i = 0; i < 14; i++) blk[i] <= '0;
        blk[14] <= {count[60:29]};
        blk[15] <= {count[28:0], 3'b000};
      end
    end
  end

  `SHA_ASSERT(a_out_only_fin, clk, rst, out_valid |-> fin)
  `SHA_ASSERT(a_no_in_busy, clk, rst, (state == ST_ROUND) |-> !in_ready)
  `SHA_ASSERT(a_wrap_out, clk, rst, (out_valid && out_ready && last_word) |=> state == ST_IDLE)
endmodule

// ===== tb/sha256_hash_core_top_tb.sv =====
// Self-checking testbench for the byte-fed SHA-256 core: digests predicted per message.
`timescale 1ns / 100ps
module sha256_hash_core_top_tb;
  import sha_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
  } digest_beat_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_hash_core_top u_top (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .byte_present, .last,
    .out_valid, .out_ready, .digest_word, .word_index, .last_word
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Digest predictor state
  logic [31:0]  hash_state [8];
  logic [31:0]  msg_window [16];
  logic [60:0]  msg_bytes;
  digest_beat_t digest_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  const logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  const logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic void compress_block();
    logic [31:0] r [8];
    logic [31:0] w, a15, a2, s0, s1, t1, t2;
    for (int i = 0; i < 8; i++) r[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = msg_window[t];
      end else begin
        a15 = msg_window[(t - 15) & 15];
        a2  = msg_window[(t - 2) & 15];
        s0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
        s1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
        w = msg_window[t & 15] + s0 + msg_window[(t - 7) & 15] + s1;
        msg_window[t & 15] = w;
      end
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[t] + w;
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4];
      r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0];
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += r[i];
  endfunction

  // The first byte of a word overwrites it; the rest are or-ed in.
  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    logic [31:0] lane;
    lane = 32'(b) << ((3 - pos[1:0]) * 8);
    if (pos[1:0] == 2'd0) msg_window[pos[5:2]] = lane;
    else msg_window[pos[5:2]] |= lane;
  endfunction

  function automatic void predict_digest(input logic [7:0] b, input logic present,
                                         input logic fin);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_beat_t e;
    if (present) begin
      pos = msg_bytes[5:0];
      place_byte(pos, b);
      msg_bytes++;
      if (pos == 6'd63) compress_block();
    end
    if (!fin) return;
    pos = msg_bytes[5:0];
    place_byte(pos, PAD_BYTE);
    for (int i = pos[5:2] + 1; i < 16; i++) msg_window[i] = '0;
    // No room for the length: close this block and pad an extra one
    if (pos >= 6'd56) begin
      compress_block();
      for (int i = 0; i < 16; i++) msg_window[i] = '0;
    end
    bit_len = {msg_bytes, 3'b000};
    msg_window[14] = bit_len[63:32];
    msg_window[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      e.word = hash_state[i];
      e.index = 3'(i);
      e.is_last = (i == 7);
      digest_q.push_back(e);
    end
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    msg_bytes = '0;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic present, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(b, present, fin);
  endtask

  task automatic send_message(input int len, input bit fin_with_byte);
    for (int i = 0; i < len; i++) begin
      // occasional empty beat, ignored by the core
      if ($urandom_range(99) < 8) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, fin_with_byte && (i == len - 1));
    end
    if (!fin_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Pause the sender until every digest has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b1);              // empty message
    send_beat(8'h5a, 1'b0, 1'b0);              // no byte, no last
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);              // last carries a byte
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);              // last with no byte
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'haa, 1'b0, 1'b1);              // empty again
    wait_drained();
  endtask

  task automatic test_random_messages(input int beat_budget);
    int len;
    while (beat_budget > 0) begin
      case ($urandom_range(9))
        0, 1, 2: len = $urandom_range(54, 66);   // around the padding split
        3:       len = $urandom_range(120, 130);
        default: len = $urandom_range(20);
      endcase
      send_message(len, $urandom_range(1));
      beat_budget -= len + 1;
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    send_message(12, 1'b1);
    send_message(9, 1'b0);
    send_message(5, 1'b1);
    wait_drained();
  endtask

  // Digest checker and receiver stalls
  always @(posedge clk) begin
    digest_beat_t e;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest beat: word %h index %0d last %b",
                   digest_word, word_index, last_word);
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word || word_index !== e.index || last_word !== e.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     e.word, e.index, e.is_last, digest_word, word_index, last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    for (int i = 0; i < 16; i++) msg_window[i] = '0;
    msg_bytes = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 59;
    test_directed();
    test_backpressure();
    test_random_messages(40);
    send_idle_pct = 59;
    recv_idle_pct = 38;
    test_random_messages(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(40);
    if (mismatches == 0 && digest_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
